>>> rtl/vpv_pkg.sv
// Shared constants, types and saturation helper for the viewport projection block.
// No dependencies; used by vpv_divider and vertex_project_to_viewport.
`default_nettype none

package vpv_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int TERM_W     = PROD_W - FRAC_BITS;
   localparam int ACC_W      = TERM_W + 2;
   localparam int DVD_W      = DATA_W + FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DVD_W);
   localparam int VP_W       = 16;
   localparam int VP_PROD_W  = DATA_W + 1 + VP_W + 1;
   localparam int VP_SUM_W   = VP_PROD_W + 1;
   localparam int ORG_W      = VP_W + FRAC_BITS;
   localparam int COEF_ADDR_W = 5;

   localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;
   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [VP_W-1:0] VIEW_W_RESET = 16'd640;
   localparam logic [VP_W-1:0] VIEW_H_RESET = 16'd480;

   typedef enum logic [0:0] {
      OP_LOAD      = 1'b0,
      OP_TRANSFORM = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_VIEWPORT_X,
      REG_VIEWPORT_Y,
      REG_VIEWPORT_WIDTH,
      REG_VIEWPORT_HEIGHT
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_DIV_START,
      ST_DIV,
      ST_VIEW_MUL,
      ST_VIEW_ADD,
      ST_DONE
   } state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < 64'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/vertex_project_to_viewport.sv
// Point projection to viewport: two 4x4 matrices in one coefficient RAM, one shared MAC.
// Load beat: written in the accept cycle, next beat taken the following cycle.
// Transform beat: 32 MAC terms, two 48-step dividers, viewport map (divide and map skipped
// when clip w is zero); next beat taken as the result appears or once an older one drains.
// Sync reset: matrices read as identity, viewport 0,0,640,480, output channel empty.
// Depends on vpv_pkg and vpv_divider.
`default_nettype none

module vertex_project_to_viewport (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // coeff_index[3:0], coeff_value[35:4], point_x[67:36], point_y[99:68], point_z[131:100]
   input  wire logic [135:0]  req_tdata,
   // op[0], matrix_select[1]
   input  wire logic [1:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // screen_x[31:0], screen_y[63:32]
   output logic [63:0]        rsp_tdata,
   // w_zero[0]
   output logic [0:0]         rsp_tuser,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [3:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int DW = vpv_pkg::DATA_W;

   // input beat fields
   logic                    req_op;
   logic                    req_mat_sel;
   logic [3:0]              req_coeff_index;
   logic signed [DW-1:0]    req_coeff_value;
   logic signed [DW-1:0]    req_point_x;
   logic signed [DW-1:0]    req_point_y;
   logic signed [DW-1:0]    req_point_z;
   logic                    req_accept;

   assign req_op          = req_tuser[0];
   assign req_mat_sel     = req_tuser[1];
   assign req_coeff_index = req_tdata[3:0];
   assign req_coeff_value = req_tdata[35:4];
   assign req_point_x     = req_tdata[67:36];
   assign req_point_y     = req_tdata[99:68];
   assign req_point_z     = req_tdata[131:100];
   assign req_accept      = req_tvalid && req_tready;

   // configuration registers
   logic signed [vpv_pkg::VP_W-1:0] vp_x_ff;
   logic signed [vpv_pkg::VP_W-1:0] vp_y_ff;
   logic [vpv_pkg::VP_W-1:0]        vp_w_ff;
   logic [vpv_pkg::VP_W-1:0]        vp_h_ff;
   logic                            csr_wr;
   vpv_pkg::reg_index_type          reg_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = vpv_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_x_ff <= '0;
         vp_y_ff <= '0;
         vp_w_ff <= vpv_pkg::VIEW_W_RESET;
         vp_h_ff <= vpv_pkg::VIEW_H_RESET;
      end else if (csr_wr) begin
         case (reg_sel)
            vpv_pkg::REG_VIEWPORT_X:      vp_x_ff <= csr_pwdata[vpv_pkg::VP_W-1:0];
            vpv_pkg::REG_VIEWPORT_Y:      vp_y_ff <= csr_pwdata[vpv_pkg::VP_W-1:0];
            vpv_pkg::REG_VIEWPORT_WIDTH:  vp_w_ff <= csr_pwdata[vpv_pkg::VP_W-1:0];
            vpv_pkg::REG_VIEWPORT_HEIGHT: vp_h_ff <= csr_pwdata[vpv_pkg::VP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         vpv_pkg::REG_VIEWPORT_X:      csr_prdata = 32'(vp_x_ff);
         vpv_pkg::REG_VIEWPORT_Y:      csr_prdata = 32'(vp_y_ff);
         vpv_pkg::REG_VIEWPORT_WIDTH:  csr_prdata = {16'd0, vp_w_ff};
         vpv_pkg::REG_VIEWPORT_HEIGHT: csr_prdata = {16'd0, vp_h_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // control
   vpv_pkg::state_type state_ff;
   vpv_pkg::state_type state_in;
   logic                   mac_issue;
   logic                   w_is_zero;
   logic                   div_start;
   logic                   zero_res;
   logic                   vp_mul_en;
   logic                   vp_add_en;
   logic                   rsp_load;
   logic                   rsp_valid_ff;
   logic                   div_x_done;
   logic                   div_y_done;

   // k: [4] projection pass, [3:2] row, [1:0] column
   logic [4:0]             k_ff;
   logic                   a_vld_ff;
   logic                   b_vld_ff;

   logic signed [DW-1:0]   pr_ff [4];
   logic signed [DW-1:0]   mv_ff [4];

   assign w_is_zero = (pr_ff[3] == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vpv_pkg::ST_IDLE: begin
            if (req_accept && (req_op == vpv_pkg::OP_TRANSFORM)) begin
               state_in = vpv_pkg::ST_MAC;
            end
         end
         vpv_pkg::ST_MAC: begin
            if (k_ff[3:0] == 4'hF) begin
               state_in = vpv_pkg::ST_DRAIN;
            end
         end
         vpv_pkg::ST_DRAIN: begin
            if (!a_vld_ff && !b_vld_ff) begin
               state_in = k_ff[4] ? vpv_pkg::ST_MAC : vpv_pkg::ST_DIV_START;
            end
         end
         vpv_pkg::ST_DIV_START: begin
            state_in = w_is_zero ? vpv_pkg::ST_DONE : vpv_pkg::ST_DIV;
         end
         vpv_pkg::ST_DIV: begin
            if (div_x_done && div_y_done) begin
               state_in = vpv_pkg::ST_VIEW_MUL;
            end
         end
         vpv_pkg::ST_VIEW_MUL: state_in = vpv_pkg::ST_VIEW_ADD;
         vpv_pkg::ST_VIEW_ADD: state_in = vpv_pkg::ST_DONE;
         vpv_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = vpv_pkg::ST_IDLE;
            end
         end
         default: state_in = vpv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == vpv_pkg::ST_IDLE);
      mac_issue  = (state_ff == vpv_pkg::ST_MAC);
      div_start  = (state_ff == vpv_pkg::ST_DIV_START) && !w_is_zero;
      zero_res   = (state_ff == vpv_pkg::ST_DIV_START) && w_is_zero;
      vp_mul_en  = (state_ff == vpv_pkg::ST_VIEW_MUL);
      vp_add_en  = (state_ff == vpv_pkg::ST_VIEW_ADD);
      rsp_load   = (state_ff == vpv_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vpv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (req_accept) begin
         k_ff <= '0;
      end else if (mac_issue) begin
         k_ff <= k_ff + 5'd1;
      end
   end

   // point latch
   logic signed [DW-1:0] pin_x_ff;
   logic signed [DW-1:0] pin_y_ff;
   logic signed [DW-1:0] pin_z_ff;

   always_ff @(posedge clock) begin
      if (req_accept && (req_op == vpv_pkg::OP_TRANSFORM)) begin
         pin_x_ff <= req_point_x;
         pin_y_ff <= req_point_y;
         pin_z_ff <= req_point_z;
      end
   end

   // coefficient RAM: address {matrix, column, row}; unwritten entries read as identity
   logic signed [DW-1:0]                coef_mem [2**vpv_pkg::COEF_ADDR_W];
   logic [2**vpv_pkg::COEF_ADDR_W-1:0]  coef_vld_ff;
   logic [vpv_pkg::COEF_ADDR_W-1:0]     load_addr;
   logic [vpv_pkg::COEF_ADDR_W-1:0]     rd_addr;
   logic                                load_we;
   logic signed [DW-1:0]                rd_ff;

   assign load_addr = {req_mat_sel, req_coeff_index};
   assign rd_addr   = {k_ff[4], k_ff[1:0], k_ff[3:2]};
   assign load_we   = req_accept && (req_op == vpv_pkg::OP_LOAD);

   always_ff @(posedge clock) begin
      if (load_we) begin
         coef_mem[load_addr] <= req_coeff_value;
      end
      if (mac_issue) begin
         rd_ff <= coef_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (load_we) begin
         coef_vld_ff[load_addr] <= 1'b1;
      end
   end

   // MAC pipe: A = RAM read, B = multiply, C = accumulate
   logic signed [DW-1:0]                opnd;
   logic [4:0]                          a_tag_ff;
   logic signed [DW-1:0]                a_opnd_ff;
   logic                                a_ent_vld_ff;
   logic signed [DW-1:0]                coef_eff;
   logic signed [vpv_pkg::PROD_W-1:0]   prod_w;
   logic signed [vpv_pkg::PROD_W-1:0]   prod_ff;
   logic [4:0]                          b_tag_ff;
   logic signed [vpv_pkg::TERM_W-1:0]   term;
   logic signed [vpv_pkg::ACC_W-1:0]    acc_ff;
   logic signed [vpv_pkg::ACC_W-1:0]    acc_sum;

   always_comb begin
      if (k_ff[4]) begin
         opnd = mv_ff[k_ff[1:0]];
      end else begin
         case (k_ff[1:0])
            2'd0:    opnd = pin_x_ff;
            2'd1:    opnd = pin_y_ff;
            2'd2:    opnd = pin_z_ff;
            default: opnd = vpv_pkg::FIX_ONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= mac_issue;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mac_issue) begin
         a_tag_ff     <= k_ff;
         a_opnd_ff    <= opnd;
         a_ent_vld_ff <= coef_vld_ff[rd_addr];
      end
   end

   always_comb begin
      if (a_ent_vld_ff) begin
         coef_eff = rd_ff;
      end else if (a_tag_ff[3:2] == a_tag_ff[1:0]) begin
         coef_eff = vpv_pkg::FIX_ONE;
      end else begin
         coef_eff = '0;
      end
   end

   assign prod_w = coef_eff * a_opnd_ff;

   always_ff @(posedge clock) begin
      if (a_vld_ff) begin
         prod_ff  <= prod_w;
         b_tag_ff <= a_tag_ff;
      end
   end

   assign term    = prod_ff[vpv_pkg::PROD_W-1:vpv_pkg::FRAC_BITS];
   assign acc_sum = ((b_tag_ff[1:0] == 2'd0) ? '0 : acc_ff) + vpv_pkg::ACC_W'(term);

   always_ff @(posedge clock) begin
      if (b_vld_ff) begin
         acc_ff <= acc_sum;
         if (b_tag_ff[1:0] == 2'd3) begin
            if (b_tag_ff[4]) begin
               pr_ff[b_tag_ff[3:2]] <= vpv_pkg::sat32(64'(acc_sum));
            end else begin
               mv_ff[b_tag_ff[3:2]] <= vpv_pkg::sat32(64'(acc_sum));
            end
         end
      end
   end

   // perspective divide
   logic signed [DW-1:0] quot_x;
   logic signed [DW-1:0] quot_y;

   vpv_divider u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (pr_ff[0]),
      .den   (pr_ff[3]),
      .done  (div_x_done),
      .quot  (quot_x)
   );

   vpv_divider u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (pr_ff[1]),
      .den   (pr_ff[3]),
      .done  (div_y_done),
      .quot  (quot_y)
   );

   // viewport map: ((n + 1) * size) >>> 1 + origin
   logic signed [DW:0]                      nd1_x;
   logic signed [DW:0]                      nd1_y;
   logic signed [vpv_pkg::VP_W:0]           size_x;
   logic signed [vpv_pkg::VP_W:0]           size_y;
   logic signed [vpv_pkg::VP_PROD_W-1:0]    vp_prod_x_ff;
   logic signed [vpv_pkg::VP_PROD_W-1:0]    vp_prod_y_ff;
   logic signed [vpv_pkg::ORG_W-1:0]        org_x;
   logic signed [vpv_pkg::ORG_W-1:0]        org_y;
   logic signed [vpv_pkg::VP_SUM_W-1:0]     sum_x;
   logic signed [vpv_pkg::VP_SUM_W-1:0]     sum_y;
   logic signed [DW-1:0]                    res_x_ff;
   logic signed [DW-1:0]                    res_y_ff;
   logic                                    res_wz_ff;

   assign nd1_x  = (DW+1)'(quot_x) + (DW+1)'(vpv_pkg::FIX_ONE);
   assign nd1_y  = (DW+1)'(quot_y) + (DW+1)'(vpv_pkg::FIX_ONE);
   assign size_x = {1'b0, vp_w_ff};
   assign size_y = {1'b0, vp_h_ff};
   assign org_x  = {vp_x_ff, {vpv_pkg::FRAC_BITS{1'b0}}};
   assign org_y  = {vp_y_ff, {vpv_pkg::FRAC_BITS{1'b0}}};
   assign sum_x  = vpv_pkg::VP_SUM_W'(vp_prod_x_ff >>> 1) + vpv_pkg::VP_SUM_W'(org_x);
   assign sum_y  = vpv_pkg::VP_SUM_W'(vp_prod_y_ff >>> 1) + vpv_pkg::VP_SUM_W'(org_y);

   always_ff @(posedge clock) begin
      if (vp_mul_en) begin
         vp_prod_x_ff <= nd1_x * size_x;
         vp_prod_y_ff <= nd1_y * size_y;
      end
      if (zero_res) begin
         res_x_ff  <= '0;
         res_y_ff  <= '0;
         res_wz_ff <= 1'b1;
      end else if (vp_add_en) begin
         res_x_ff  <= vpv_pkg::sat32(64'(sum_x));
         res_y_ff  <= vpv_pkg::sat32(64'(sum_y));
         res_wz_ff <= 1'b0;
      end
   end

   // output register
   logic [63:0] rsp_data_ff;
   logic        rsp_wz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {res_y_ff, res_x_ff};
         rsp_wz_ff   <= res_wz_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_wz_ff;

endmodule

`default_nettype wire

>>> rtl/vpv_divider.sv
// Sequential signed divider: (num << FRAC_BITS) / den, truncated toward zero, saturated.
// Restoring, one quotient bit per cycle. Depends on vpv_pkg.
`default_nettype none

module vpv_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [vpv_pkg::DATA_W-1:0]   num,
   input  wire logic signed [vpv_pkg::DATA_W-1:0]   den,
   output logic                                     done,
   output logic signed [vpv_pkg::DATA_W-1:0]        quot
);

   logic                                busy_ff;
   logic                                fin_ff;
   logic                                done_ff;
   logic                                neg_ff;
   logic [vpv_pkg::DIV_CNT_W-1:0]       cnt_ff;
   logic [vpv_pkg::DVD_W-1:0]           dvd_ff;
   logic [vpv_pkg::DATA_W-1:0]          rem_ff;
   logic [vpv_pkg::DATA_W-1:0]          den_ff;
   logic signed [vpv_pkg::DATA_W-1:0]   quot_ff;

   logic [vpv_pkg::DATA_W-1:0]          num_mag;
   logic [vpv_pkg::DATA_W-1:0]          den_mag;
   logic [vpv_pkg::DATA_W:0]            rem_sh;
   logic                                fits;
   logic [vpv_pkg::DATA_W-1:0]          rem_next;
   logic                                pos_over;
   logic                                neg_over;
   logic [vpv_pkg::DATA_W-1:0]          q_low;
   logic signed [vpv_pkg::DATA_W-1:0]   quot_in;

   assign num_mag  = num[vpv_pkg::DATA_W-1] ? (~num + vpv_pkg::DATA_W'(1)) : num;
   assign den_mag  = den[vpv_pkg::DATA_W-1] ? (~den + vpv_pkg::DATA_W'(1)) : den;
   assign rem_sh   = {rem_ff, dvd_ff[vpv_pkg::DVD_W-1]};
   assign fits     = rem_sh >= {1'b0, den_ff};
   assign rem_next = fits ? vpv_pkg::DATA_W'(rem_sh - {1'b0, den_ff})
                          : rem_sh[vpv_pkg::DATA_W-1:0];

   assign q_low    = dvd_ff[vpv_pkg::DATA_W-1:0];
   assign pos_over = |dvd_ff[vpv_pkg::DVD_W-1:vpv_pkg::DATA_W-1];
   assign neg_over = (|dvd_ff[vpv_pkg::DVD_W-1:vpv_pkg::DATA_W]) ||
                     (dvd_ff[vpv_pkg::DATA_W-1] && (|dvd_ff[vpv_pkg::DATA_W-2:0]));

   always_comb begin
      if (neg_ff) begin
         quot_in = neg_over ? vpv_pkg::SAT_MIN : (~q_low + vpv_pkg::DATA_W'(1));
      end else begin
         quot_in = pos_over ? vpv_pkg::SAT_MAX : q_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {num_mag, {vpv_pkg::FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         den_ff <= den_mag;
         neg_ff <= num[vpv_pkg::DATA_W-1] ^ den[vpv_pkg::DATA_W-1];
         cnt_ff <= vpv_pkg::DIV_CNT_W'(vpv_pkg::DVD_W - 1);
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[vpv_pkg::DVD_W-2:0], fits};
         rem_ff <= rem_next;
         cnt_ff <= cnt_ff - vpv_pkg::DIV_CNT_W'(1);
      end
      if (fin_ff) begin
         quot_ff <= quot_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire
